// ===== design/vmg_pkg.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// vmg_pkg
// Shared widths, codes and helpers for the voter model jump engine.
//------------------------------------------------------------------------------
`default_nettype none

package vmg_pkg;

   localparam int CNT_W      = 13;  // agent counts
   localparam int RATE_W     = 24;  // Q8.16 rates
   localparam int Q_W        = 39;  // one transition rate
   localparam int LAM_W      = 42;  // total rate, cumulative sums, scaled choice
   localparam int DVD_W      = 50;  // divider dividend / quotient
   localparam int TIME_W     = 48;  // Q24.24 time
   localparam int IN_W       = 32;  // random inputs
   localparam int MUL_W      = 32;  // multiplier operand
   localparam int DIV_STEPS  = DVD_W;
   localparam int DIV_CNT_W  = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int NUM_RATES  = 6;
   localparam int K_W        = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POPULATION  = 3'd0,
      CSR_COPY        = 3'd1,
      CSR_EXTERNALIZE = 3'd2,
      CSR_INTERNALIZE = 3'd3,
      CSR_START_EXT   = 3'd4,
      CSR_START_INT   = 3'd5,
      CSR_START_BOTH  = 3'd6,
      CSR_UNUSED      = 3'd7
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_RUNNING = 2'd0,
      ST_BLUE    = 2'd1,
      ST_RED     = 2'd2,
      ST_ZERO    = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_CAPTURE,
      DP_LOAD,
      DP_CLAMP,
      DP_MUL1,
      DP_MUL2,
      DP_DIVN,
      DP_MUL3,
      DP_ACC,
      DP_SCALE_LO,
      DP_SCALE_HI,
      DP_SCALE_ADD,
      DP_SCAN,
      DP_APPLY,
      DP_DIVT,
      DP_TADD,
      DP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type      op;
      logic [K_W-1:0] k;
   } dp_cmd_type;

   typedef struct packed {
      logic       div_done;
      logic       found;
      logic       out_free;
      status_type status;
   } dp_stat_type;

   // transitions with a copy term (divided by n)
   function automatic logic has_div(input logic [K_W-1:0] k);
      return (k == 3'd0) || (k == 3'd1) || (k == 3'd3) || (k == 3'd5);
   endfunction

   // transitions with a linear term
   function automatic logic has_lin(input logic [K_W-1:0] k);
      return (k == 3'd1) || (k == 3'd2) || (k == 3'd3) || (k == 3'd4);
   endfunction

endpackage

`default_nettype wire

// ===== design/vmg_channels.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// vmg channel interfaces
// Valid/ready channels for jump requests and state reports.
//------------------------------------------------------------------------------
`default_nettype none

interface vmg_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [31:0] choice_uniform;
   logic [31:0] exp_variate;
   modport source (output valid, op, choice_uniform, exp_variate, input ready);
   modport sink   (input valid, op, choice_uniform, exp_variate, output ready);
endinterface

interface vmg_rsp_if;
   logic        valid;
   logic        ready;
   logic [12:0] ext_red;
   logic [12:0] int_red;
   logic [12:0] both_red;
   logic [47:0] sim_time;
   logic [1:0]  status;
   modport source (output valid, ext_red, int_red, both_red, sim_time, status,
                   input ready);
   modport sink   (input valid, ext_red, int_red, both_red, sim_time, status,
                   output ready);
endinterface

`default_nettype wire

// ===== design/vmg_div.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// vmg_div
// Radix-2 restoring divider, one quotient bit per cycle.
//------------------------------------------------------------------------------
`default_nettype none

module vmg_div
   import vmg_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [LAM_W-1:0] divisor,
   output logic                  done,
   output logic [DVD_W-1:0]      quotient
);

   logic [DVD_W-1:0]     dvd_ff, dvd_in;
   logic [LAM_W:0]       rem_ff, rem_in;
   logic [LAM_W-1:0]     dsr_ff;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [LAM_W:0]       rem_sh;
   logic                 ge;

   assign rem_sh = {rem_ff[LAM_W-1:0], dvd_ff[DVD_W-1]};
   assign ge     = rem_sh >= {1'b0, dsr_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         cnt_in  = DIV_CNT_W'(DIV_STEPS - 1);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sh - {1'b0, dsr_ff} : rem_sh;
         dvd_in = {dvd_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      if (start) dsr_ff <= divisor;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

`default_nettype wire

// ===== design/vmg_datapath.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// vmg_datapath
// Counts, config, shared multiplier, divider, rate sums and result register.
//------------------------------------------------------------------------------
`default_nettype none

module vmg_datapath
   import vmg_pkg::*;
#(
   parameter int MAX_AGENTS = 4096
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data,
   input  wire logic [IN_W-1:0]       in_uniform,
   input  wire logic [IN_W-1:0]       in_exp,
   input  wire dp_cmd_type            cmd,
   output dp_stat_type                stat,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [CNT_W-1:0]           out_ext,
   output logic [CNT_W-1:0]           out_int,
   output logic [CNT_W-1:0]           out_both,
   output logic [TIME_W-1:0]          out_time,
   output logic [1:0]                 out_status
);

   // config
   logic [CNT_W-1:0]  pop_ff, sext_ff, sint_ff, sboth_ff;
   logic [RATE_W-1:0] rc_ff, re_ff, ri_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pop_ff   <= CNT_W'(1024);
         rc_ff    <= RATE_W'(65536);
         re_ff    <= RATE_W'(65536);
         ri_ff    <= RATE_W'(65536);
         sext_ff  <= '0;
         sint_ff  <= '0;
         sboth_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_idx_type'(csr_index))
            CSR_POPULATION:  pop_ff   <= csr_write_data[CNT_W-1:0];
            CSR_COPY:        rc_ff    <= csr_write_data;
            CSR_EXTERNALIZE: re_ff    <= csr_write_data;
            CSR_INTERNALIZE: ri_ff    <= csr_write_data;
            CSR_START_EXT:   sext_ff  <= csr_write_data[CNT_W-1:0];
            CSR_START_INT:   sint_ff  <= csr_write_data[CNT_W-1:0];
            CSR_START_BOTH:  sboth_ff <= csr_write_data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // effective population
   logic [CNT_W-1:0] n;
   always_comb begin
      priority if (pop_ff == '0)
         n = CNT_W'(1);
      else if ({4'b0, pop_ff} > 17'(MAX_AGENTS))
         n = CNT_W'(MAX_AGENTS);
      else
         n = pop_ff;
   end

   // state
   logic [CNT_W-1:0]  e_ff, i_ff, b_ff;
   logic [TIME_W-1:0] t_ff;
   logic [IN_W-1:0]   u_ff, ev_ff;
   logic [63:0]       prod_ff;
   logic [Q_W-1:0]    q_ff [NUM_RATES-1];
   logic [LAM_W-1:0]  lam_ff, r_ff, cum_ff;

   // clamp to a consistent state
   logic [CNT_W-1:0] ec, ic, lo, hi, bl, bc;
   logic [CNT_W:0]   esum;
   always_comb begin
      ec   = (e_ff > n) ? n : e_ff;
      ic   = (i_ff > n) ? n : i_ff;
      esum = {1'b0, ec} + {1'b0, ic};
      lo   = (esum > {1'b0, n}) ? CNT_W'(esum - {1'b0, n}) : '0;
      hi   = (ec < ic) ? ec : ic;
      bl   = (b_ff < lo) ? lo : b_ff;
      bc   = (bl > hi) ? hi : bl;
   end

   // rate operands
   logic [CNT_W-1:0] m_v, ib, eb, ne;
   assign m_v = CNT_W'({1'b0, n} + {1'b0, b_ff} - {1'b0, e_ff} - {1'b0, i_ff});
   assign ib  = i_ff - b_ff;
   assign eb  = e_ff - b_ff;
   assign ne  = n - e_ff;

   logic [CNT_W-1:0]  fa, fb, fc;
   logic [RATE_W-1:0] fr;
   always_comb begin
      unique case (cmd.k)
         3'd0:    begin fa = e_ff; fb = m_v;  fc = '0; fr = re_ff; end
         3'd1:    begin fa = ib;   fb = e_ff; fc = ib; fr = re_ff; end
         3'd2:    begin fa = '0;   fb = '0;   fc = eb; fr = ri_ff; end
         3'd3:    begin fa = eb;   fb = ne;   fc = eb; fr = re_ff; end
         3'd4:    begin fa = '0;   fb = '0;   fc = ib; fr = ri_ff; end
         default: begin fa = b_ff; fb = ne;   fc = '0; fr = re_ff; end
      endcase
   end

   // shared multiplier
   logic [MUL_W-1:0] ma, mb;
   always_comb begin
      ma = '0;
      mb = '0;
      unique case (cmd.op)
         DP_MUL1:     begin ma = MUL_W'(fa); mb = MUL_W'(fb); end
         DP_MUL2:     begin ma = MUL_W'(prod_ff[2*CNT_W-1:0]); mb = MUL_W'(rc_ff); end
         DP_MUL3:     begin ma = MUL_W'(fc); mb = MUL_W'(fr); end
         DP_SCALE_LO: begin ma = lam_ff[MUL_W-1:0]; mb = u_ff; end
         DP_SCALE_HI: begin ma = MUL_W'(lam_ff[LAM_W-1:MUL_W]); mb = u_ff; end
         default: ;
      endcase
   end

   // divider
   logic             div_start, div_done;
   logic [DVD_W-1:0] div_dvd, div_q;
   logic [LAM_W-1:0] div_dsr;
   assign div_start = (cmd.op == DP_DIVN) || (cmd.op == DP_DIVT);
   assign div_dvd   = (cmd.op == DP_DIVT) ? DVD_W'({ev_ff, 16'b0}) : prod_ff[DVD_W-1:0];
   assign div_dsr   = (cmd.op == DP_DIVT) ? lam_ff : LAM_W'(n);

   vmg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .done     (div_done),
      .quotient (div_q)
   );

   // rate accumulate, scan, time
   logic [Q_W-1:0]    q_add;
   logic [LAM_W-1:0]  cum_in;
   logic [TIME_W:0]   t_sum;
   assign q_add  = (has_div(cmd.k) ? div_q[Q_W-1:0] : '0) +
                   (has_lin(cmd.k) ? prod_ff[Q_W-1:0] : '0);
   assign cum_in = cum_ff + LAM_W'(q_ff[cmd.k]);
   assign t_sum  = {1'b0, t_ff} + {1'b0, div_q[TIME_W-1:0]};

   status_type st;
   always_comb begin
      priority if (e_ff == '0 && i_ff == '0) st = ST_BLUE;
      else if (e_ff == n && i_ff == n)       st = ST_RED;
      else if (lam_ff == '0)                 st = ST_ZERO;
      else                                   st = ST_RUNNING;
   end

   logic out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_ff <= '0;
         i_ff <= '0;
         b_ff <= '0;
         t_ff <= '0;
      end else begin
         unique case (cmd.op)
            DP_LOAD: begin
               e_ff <= sext_ff;
               i_ff <= sint_ff;
               b_ff <= sboth_ff;
               t_ff <= '0;
            end
            DP_CLAMP: begin
               e_ff <= ec;
               i_ff <= ic;
               b_ff <= bc;
            end
            DP_APPLY: begin
               unique case (cmd.k)
                  3'd0: e_ff <= e_ff + 1'b1;
                  3'd1: begin e_ff <= e_ff + 1'b1; b_ff <= b_ff + 1'b1; end
                  3'd2: begin i_ff <= i_ff + 1'b1; b_ff <= b_ff + 1'b1; end
                  3'd3: e_ff <= e_ff - 1'b1;
                  3'd4: i_ff <= i_ff - 1'b1;
                  default: begin e_ff <= e_ff - 1'b1; b_ff <= b_ff - 1'b1; end
               endcase
            end
            DP_TADD: t_ff <= t_sum[TIME_W] ? '1 : t_sum[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         DP_CAPTURE: begin
            u_ff  <= in_uniform;
            ev_ff <= in_exp;
         end
         DP_MUL1, DP_MUL2, DP_MUL3, DP_SCALE_LO: prod_ff <= 64'(ma) * 64'(mb);
         DP_SCALE_HI: begin
            prod_ff <= 64'(ma) * 64'(mb);
            r_ff    <= LAM_W'(prod_ff[63:32]);
         end
         DP_SCALE_ADD: begin
            r_ff   <= r_ff + prod_ff[LAM_W-1:0];
            cum_ff <= '0;
         end
         DP_CLAMP, DP_TADD: lam_ff <= '0;
         DP_ACC: begin
            lam_ff <= lam_ff + LAM_W'(q_add);
            if (cmd.k < K_W'(NUM_RATES - 1)) q_ff[cmd.k] <= q_add;
         end
         DP_SCAN: cum_ff <= cum_in;
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.op == DP_OUT) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.op == DP_OUT) begin
         out_ext    <= e_ff;
         out_int    <= i_ff;
         out_both   <= b_ff;
         out_time   <= t_ff;
         out_status <= st;
      end
   end

   assign out_valid     = out_valid_ff;
   assign stat.div_done = div_done;
   assign stat.found    = r_ff < cum_in;
   assign stat.out_free = !out_valid_ff || out_ready;
   assign stat.status   = st;

endmodule

`default_nettype wire

// ===== design/vmg_ctrl.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// vmg_ctrl
// Sequencer for restart and jump: rate passes, choice, time update.
//------------------------------------------------------------------------------
`default_nettype none

module vmg_ctrl
   import vmg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   input  wire logic        in_op,
   output logic             in_ready,
   output dp_cmd_type       cmd,
   input  wire dp_stat_type stat
);

   typedef enum logic [19:0] {
      S_IDLE   = 20'h00001,
      S_LOAD   = 20'h00002,
      S_CLAMP  = 20'h00004,
      S_MUL1   = 20'h00008,
      S_MUL2   = 20'h00010,
      S_DIVNS  = 20'h00020,
      S_DIVNW  = 20'h00040,
      S_MUL3   = 20'h00080,
      S_ACC    = 20'h00100,
      S_CHECK  = 20'h00200,
      S_SCLO   = 20'h00400,
      S_SCHI   = 20'h00800,
      S_SCADD  = 20'h01000,
      S_SCAN   = 20'h02000,
      S_APPLY  = 20'h04000,
      S_DIVTS  = 20'h08000,
      S_DIVTW  = 20'h10000,
      S_TADD   = 20'h20000,
      S_FINISH = 20'h40000,
      S_SPARE  = 20'h80000
   } state_type;

   state_type      state_ff, state_in;
   logic [K_W-1:0] k_ff, k_in;
   logic           op_ff, op_in;
   logic           pass_ff, pass_in;

   function automatic state_type rate_entry(input logic [K_W-1:0] k);
      return has_div(k) ? S_MUL1 : S_MUL3;
   endfunction

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      op_in    = op_ff;
      pass_in  = pass_ff;
      cmd.op   = DP_NOP;
      cmd.k    = k_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd.op   = DP_CAPTURE;
               op_in    = in_op;
               pass_in  = 1'b0;
               state_in = in_op ? S_CLAMP : S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.op   = DP_LOAD;
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            cmd.op   = DP_CLAMP;
            k_in     = '0;
            state_in = rate_entry('0);
         end
         S_MUL1: begin
            cmd.op   = DP_MUL1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.op   = DP_MUL2;
            state_in = S_DIVNS;
         end
         S_DIVNS: begin
            cmd.op   = DP_DIVN;
            state_in = S_DIVNW;
         end
         S_DIVNW: begin
            if (stat.div_done) state_in = has_lin(k_ff) ? S_MUL3 : S_ACC;
         end
         S_MUL3: begin
            cmd.op   = DP_MUL3;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.op = DP_ACC;
            if (k_ff == K_W'(NUM_RATES - 1)) begin
               state_in = S_CHECK;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = rate_entry(k_ff + 1'b1);
            end
         end
         S_CHECK: begin
            if (!op_ff || pass_ff || stat.status != ST_RUNNING) state_in = S_FINISH;
            else                                               state_in = S_SCLO;
         end
         S_SCLO: begin
            cmd.op   = DP_SCALE_LO;
            state_in = S_SCHI;
         end
         S_SCHI: begin
            cmd.op   = DP_SCALE_HI;
            state_in = S_SCADD;
         end
         S_SCADD: begin
            cmd.op   = DP_SCALE_ADD;
            k_in     = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.op = DP_SCAN;
            priority if (stat.found) begin
               state_in = S_APPLY;
            end else if (k_ff == K_W'(NUM_RATES - 2)) begin
               k_in     = K_W'(NUM_RATES - 1);
               state_in = S_APPLY;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_APPLY: begin
            cmd.op   = DP_APPLY;
            state_in = S_DIVTS;
         end
         S_DIVTS: begin
            cmd.op   = DP_DIVT;
            state_in = S_DIVTW;
         end
         S_DIVTW: begin
            if (stat.div_done) state_in = S_TADD;
         end
         S_TADD: begin
            cmd.op   = DP_TADD;
            pass_in  = 1'b1;
            k_in     = '0;
            state_in = rate_entry('0);
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.op   = DP_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= '0;
         op_ff    <= 1'b0;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         op_ff    <= op_in;
         pass_ff  <= pass_in;
      end
   end

   assign in_ready = (state_ff == S_IDLE);

endmodule

`default_nettype wire

// ===== design/voter_model_gillespie_step_top.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// voter_model_gillespie_step_top
// One restart or Gillespie jump of a two-opinion voter model per request item.
//------------------------------------------------------------------------------
// Divider: the radix-2 divider serves four copy-rate divisions per rate pass
//   plus the time divide. A restart, or a jump at consensus or zero rate,
//   ends after the first rate pass; other jumps run a second one.
// Throughput: one item at a time; the next item is taken once the result
//   sits in the output register.
// Reset: synchronous, active high; counts and time clear, config registers
//   take their defaults, no result pending.
`default_nettype none

module voter_model_gillespie_step_top
   import vmg_pkg::*;
#(
   parameter int MAX_AGENTS = 4096   // clamp limit for the population register
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   vmg_req_if.sink                    req_channel,
   vmg_rsp_if.source                  rsp_channel,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   // The controller walks each item through: optional restart load, clamp, six
   // rate terms (product, copy product, divide by n, linear term, sum), status
   // check, and for a running jump choice scaling and scan, count update, time
   // divide and a second rate pass so the reported status matches new counts.
   dp_cmd_type  cmd;
   dp_stat_type stat;

   vmg_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_channel.valid),
      .in_op    (req_channel.op),
      .in_ready (req_channel.ready),
      .cmd      (cmd),
      .stat     (stat)
   );

   vmg_datapath #(
      .MAX_AGENTS (MAX_AGENTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .in_uniform       (req_channel.choice_uniform),
      .in_exp           (req_channel.exp_variate),
      .cmd              (cmd),
      .stat             (stat),
      .out_valid        (rsp_channel.valid),
      .out_ready        (rsp_channel.ready),
      .out_ext          (rsp_channel.ext_red),
      .out_int          (rsp_channel.int_red),
      .out_both         (rsp_channel.both_red),
      .out_time         (rsp_channel.sim_time),
      .out_status       (rsp_channel.status)
   );

   // one item in flight: no second accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_channel.valid && req_channel.ready |=> !req_channel.ready)
      else $error("second item accepted while busy");

   // reported counts stay consistent
   a_both_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_channel.valid |-> (rsp_channel.both_red <= rsp_channel.ext_red) &&
                            (rsp_channel.both_red <= rsp_channel.int_red))
      else $error("both count exceeds a single count");

   // all-blue consensus means every count is zero
   a_blue: assert property (@(posedge clock) disable iff (reset)
      rsp_channel.valid && rsp_channel.status == ST_BLUE |->
         rsp_channel.ext_red == '0 && rsp_channel.int_red == '0 &&
         rsp_channel.both_red == '0)
      else $error("blue consensus with red agents");

   // all-red consensus means the three counts agree
   a_red: assert property (@(posedge clock) disable iff (reset)
      rsp_channel.valid && rsp_channel.status == ST_RED |->
         rsp_channel.ext_red == rsp_channel.int_red &&
         rsp_channel.both_red == rsp_channel.ext_red)
      else $error("red consensus with unequal counts");

endmodule

`default_nettype wire

// ===== tb/sv/tb_voter_model_gillespie_step_top.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_voter_model_gillespie_step_top
// Self-checking bench for the voter model jump engine. A scoreboard class
// predicts counts, time and status per request item and checks each report.
//------------------------------------------------------------------------------
`default_nettype none

module tb_voter_model_gillespie_step_top;
   import vmg_pkg::*;

   // one expected state report
   typedef struct {
      logic [12:0] ext_red;
      logic [12:0] int_red;
      logic [12:0] both_red;
      logic [47:0] sim_time;
      status_type  status;
   } report_type;

   // one full register setting
   typedef struct {
      logic [23:0] pop;
      logic [23:0] rc;
      logic [23:0] re;
      logic [23:0] ri;
      logic [23:0] se;
      logic [23:0] si;
      logic [23:0] sb;
   } setup_type;

   class vmg_scoreboard;
      logic [63:0] pop, rc, re, ri, se, si, sb;
      logic [63:0] e, i, b, t;
      report_type  pending[$];
      int          errors;

      function new();
         pop = 1024; rc = 65536; re = 65536; ri = 65536;
         se = 0; si = 0; sb = 0;
         e = 0; i = 0; b = 0; t = 0;
         errors = 0;
      endfunction

      function void write_reg(csr_idx_type idx, logic [23:0] v);
         case (idx)
            CSR_POPULATION:  pop = 64'(v[12:0]);
            CSR_COPY:        rc  = 64'(v);
            CSR_EXTERNALIZE: re  = 64'(v);
            CSR_INTERNALIZE: ri  = 64'(v);
            CSR_START_EXT:   se  = 64'(v[12:0]);
            CSR_START_INT:   si  = 64'(v[12:0]);
            CSR_START_BOTH:  sb  = 64'(v[12:0]);
            default: ;
         endcase
      endfunction

      function logic [63:0] agents();
         logic [63:0] n;
         n = pop;
         if (n < 1) n = 1;
         if (n > 4096) n = 4096;
         return n;
      endfunction

      // pull counts back into a feasible region for n agents
      function void fix_counts(logic [63:0] n);
         logic [63:0] lo, hi;
         if (e > n) e = n;
         if (i > n) i = n;
         lo = (e + i > n) ? e + i - n : 0;
         hi = (e < i) ? e : i;
         if (b < lo) b = lo;
         if (b > hi) b = hi;
      endfunction

      function logic [63:0] rates(logic [63:0] n, output logic [63:0] q [6]);
         logic [63:0] m;
         m = n + b - e - i;
         q[0] = (e * m * rc) / n;
         q[1] = ((i - b) * e * rc) / n + (i - b) * re;
         q[2] = (e - b) * ri;
         q[3] = ((e - b) * (n - e) * rc) / n + (e - b) * re;
         q[4] = (i - b) * ri;
         q[5] = (b * (n - e) * rc) / n;
         return q[0] + q[1] + q[2] + q[3] + q[4] + q[5];
      endfunction

      function void note_item(logic op, logic [31:0] u, logic [31:0] ev);
         logic [63:0] n, lam, r, cum, dt;
         logic [63:0] q [6];
         logic        held;
         int          k;
         report_type  rep;
         n = agents();
         if (op == 1'b0) begin
            e = se; i = si; b = sb;
            fix_counts(n);
            t = 0;
         end else begin
            fix_counts(n);
            held = (e == 0 && i == 0) || (e == n && i == n);
            lam = rates(n, q);
            if (!held && lam != 0) begin
               r = (lam >> 32) * u + (((lam & 64'hFFFF_FFFF) * u) >> 32);
               cum = 0;
               k = 5;
               for (int j = 0; j < 5; j++) begin
                  cum += q[j];
                  if (r < cum) begin
                     k = j;
                     break;
                  end
               end
               case (k)
                  0: e += 1;
                  1: begin e += 1; b += 1; end
                  2: begin i += 1; b += 1; end
                  3: e -= 1;
                  4: i -= 1;
                  default: begin e -= 1; b -= 1; end
               endcase
               e &= 64'h1FFF; i &= 64'h1FFF; b &= 64'h1FFF;
               dt = ({32'd0, ev} << 16) / lam;
               if (dt > 64'hFFFF_FFFF_FFFF - t) t = 64'hFFFF_FFFF_FFFF;
               else t += dt;
            end
         end
         rep.ext_red  = e[12:0];
         rep.int_red  = i[12:0];
         rep.both_red = b[12:0];
         rep.sim_time = t[47:0];
         if (e == 0 && i == 0)      rep.status = ST_BLUE;
         else if (e == n && i == n) rep.status = ST_RED;
         else if (rates(n, q) == 0) rep.status = ST_ZERO;
         else                       rep.status = ST_RUNNING;
         pending.push_back(rep);
      endfunction

      function void check_result(logic [12:0] er, logic [12:0] ir, logic [12:0] br,
                                 logic [47:0] tm, logic [1:0] st);
         report_type x;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected report: e=%0d i=%0d b=%0d t=%h s=%0d",
                        er, ir, br, tm, st);
            return;
         end
         x = pending.pop_front();
         if (x.ext_red !== er || x.int_red !== ir || x.both_red !== br ||
             x.sim_time !== tm || x.status !== st) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: exp e=%0d i=%0d b=%0d t=%h s=%0d, ",
                        x.ext_red, x.int_red, x.both_red, x.sim_time, x.status,
                        "got e=%0d i=%0d b=%0d t=%h s=%0d",
                        er, ir, br, tm, st);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   vmg_req_if req_bus();
   vmg_rsp_if rsp_bus();

   vmg_scoreboard board = new();

   // sender and receiver idle modes; 1 means no gaps for a stretch
   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;

   always #5 clock = ~clock;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.op = 1'b0;
      req_bus.choice_uniform = '0;
      req_bus.exp_variate = '0;
      rsp_bus.ready = 1'b0;
   end

   voter_model_gillespie_step_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_bus),
      .rsp_channel      (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Report side: random stall before each report, then hold ready until taken.
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = rsp_burst ? 0 : $urandom_range(0, 11);
         if ($urandom_range(0, 59) == 0) rsp_burst = ~rsp_burst;
         repeat (gap) begin
            @(negedge clock);
            rsp_bus.ready = 1'b0;
         end
         @(negedge clock);
         rsp_bus.ready = 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         board.check_result(rsp_bus.ext_red, rsp_bus.int_red, rsp_bus.both_red,
                            rsp_bus.sim_time, rsp_bus.status);
      end
   end

   // One request item: optional gap, then valid held until the handshake.
   task automatic send_item(logic op, logic [31:0] u, logic [31:0] ev);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 11);
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
      end
      @(negedge clock);
      req_bus.valid = 1'b1;
      req_bus.op = op;
      req_bus.choice_uniform = u;
      req_bus.exp_variate = ev;
      do @(posedge clock); while (!req_bus.ready);
      board.note_item(op, u, ev);
   endtask

   // Drop valid and wait for every outstanding report.
   task automatic drain();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [23:0] v);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = v;
      board.write_reg(idx, v);
   endtask

   // Only called with the engine idle.
   task automatic load_setup(setup_type s);
      write_csr(CSR_POPULATION, s.pop);
      write_csr(CSR_COPY, s.rc);
      write_csr(CSR_EXTERNALIZE, s.re);
      write_csr(CSR_INTERNALIZE, s.ri);
      write_csr(CSR_START_EXT, s.se);
      write_csr(CSR_START_INT, s.si);
      write_csr(CSR_START_BOTH, s.sb);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   function automatic logic [23:0] pick_rate();
      case ($urandom_range(0, 5))
         0:       return 24'd0;
         1:       return 24'hFFFFFF;
         2:       return 24'($urandom_range(1, 255));
         3:       return 24'($urandom_range(16384, 262144));
         default: return 24'($urandom());
      endcase
   endfunction

   // Random setting; start counts mostly feasible, sometimes arbitrary.
   function automatic setup_type pick_setup();
      setup_type s;
      int        n;
      case ($urandom_range(0, 7))
         0, 1:    n = $urandom_range(2, 8);
         2, 3:    n = $urandom_range(9, 64);
         4:       n = $urandom_range(65, 4095);
         5:       n = 4096;
         6:       n = 1;
         default: n = $urandom_range(0, 8191);   // may clamp
      endcase
      s.pop = {11'($urandom_range(0, 2047)), n[12:0]};
      s.rc = pick_rate();
      s.re = pick_rate();
      s.ri = pick_rate();
      if ($urandom_range(0, 3) == 0) begin
         s.se = 24'($urandom());
         s.si = 24'($urandom());
         s.sb = 24'($urandom());
      end else begin
         s.se = 24'($urandom_range(0, (n > 4096) ? 4096 : n));
         s.si = 24'($urandom_range(0, (n > 4096) ? 4096 : n));
         s.sb = 24'($urandom_range(0, (s.se < s.si) ? s.se : s.si));
      end
      return s;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 19))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   initial begin
      setup_type s;
      int        steps;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // ---- directed part ----
      // reset state: all-blue consensus, jump holds
      send_item(1'b1, 32'h1234_5678, 32'h0100_0000);
      send_item(1'b0, 32'd0, 32'd0);
      drain();

      // inconsistent start counts are clamped; extreme rates and inputs
      s = '{pop: 24'd10, rc: 24'hFFFFFF, re: 24'hFFFFFF, ri: 24'hFFFFFF,
            se: 24'd20, si: 24'd3, sb: 24'd9};
      load_setup(s);
      send_item(1'b0, 32'd0, 32'd0);
      send_item(1'b1, 32'd0, 32'hFFFF_FFFF);
      send_item(1'b1, 32'hFFFF_FFFF, 32'd0);
      send_item(1'b1, 32'h8000_0000, 32'h0100_0000);
      drain();

      // zero total rate without consensus
      s = '{pop: 24'd50, rc: 24'd0, re: 24'd0, ri: 24'd0,
            se: 24'd5, si: 24'd2, sb: 24'd1};
      load_setup(s);
      send_item(1'b0, 32'd0, 32'd0);
      send_item(1'b1, 32'h4000_0000, 32'h0100_0000);
      drain();

      // tiny total rate: time saturates after a couple of jumps
      s = '{pop: 24'd4096, rc: 24'd0, re: 24'd0, ri: 24'd1,
            se: 24'd1, si: 24'd1, sb: 24'd0};
      load_setup(s);
      send_item(1'b0, 32'd0, 32'd0);
      repeat (3) send_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      drain();

      // all-red consensus, population register zero and above the clamp
      s = '{pop: 24'd3, rc: 24'd65536, re: 24'd65536, ri: 24'd65536,
            se: 24'd3, si: 24'd3, sb: 24'd3};
      load_setup(s);
      send_item(1'b0, 32'd0, 32'd0);
      send_item(1'b1, 32'h7777_7777, 32'h0100_0000);
      drain();
      write_csr(CSR_POPULATION, 24'd0);
      write_csr(CSR_UNUSED, 24'hFFFFFF);
      @(negedge clock);
      csr_write_enable = 1'b0;
      send_item(1'b1, 32'h1111_1111, 32'h0100_0000);   // counts clamp to n=1
      send_item(1'b0, 32'd0, 32'd0);
      drain();
      write_csr(CSR_POPULATION, 24'hFF_FFFF);
      @(negedge clock);
      csr_write_enable = 1'b0;
      send_item(1'b0, 32'd0, 32'd0);
      send_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      drain();

      // ---- random part: restart then mostly jumps per setting ----
      for (int p = 0; p < 12; p++) begin
         load_setup(pick_setup());
         req_burst = ($urandom_range(0, 3) == 0);
         steps = 118;
         send_item(1'b0, $urandom(), $urandom());
         for (int k = 0; k < steps; k++) begin
            case ($urandom_range(0, 99))
               0, 1, 2, 3, 4, 5, 6: send_item(1'b0, pick_word(), pick_word());
               7, 8, 9:             send_item(1'($urandom_range(0, 1)), $urandom(),
                                              $urandom());
               default:             send_item(1'b1, pick_word(), pick_word());
            endcase
            if ($urandom_range(0, 39) == 0) req_burst = ~req_burst;
         end
         drain();
      end

      repeat (600) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
